[hdl/rc4_pkg.sv]
package rc4_pkg;

  localparam int KEY_LEN_W = 9;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;
  localparam int MAX_KEY_BYTES_DEF = 256;
  localparam int STEP_W = 4;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] key_index;
    logic [7:0] key_byte;
  } cmd_t;

  typedef struct packed {
    logic [7:0] keystream_byte;
    logic       schedule_done;
  } res_t;

  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_SCHED = 2'd1;
  localparam logic [1:0] OP_GEN   = 2'd2;

  // sequencer steps
  localparam logic [STEP_W-1:0] STEP_IDLE        = 4'd0;
  localparam logic [STEP_W-1:0] STEP_SCHED_START = 4'd1;
  localparam logic [STEP_W-1:0] STEP_FILL        = 4'd2;
  localparam logic [STEP_W-1:0] STEP_KS_INIT     = 4'd3;
  localparam logic [STEP_W-1:0] STEP_KS_A        = 4'd4;
  localparam logic [STEP_W-1:0] STEP_KS_B        = 4'd5;
  localparam logic [STEP_W-1:0] STEP_KS_C        = 4'd6;
  localparam logic [STEP_W-1:0] STEP_KS_D        = 4'd7;
  localparam logic [STEP_W-1:0] STEP_KS_END      = 4'd8;
  localparam logic [STEP_W-1:0] STEP_G0          = 4'd9;
  localparam logic [STEP_W-1:0] STEP_G1          = 4'd10;
  localparam logic [STEP_W-1:0] STEP_G2          = 4'd11;
  localparam logic [STEP_W-1:0] STEP_G3          = 4'd12;
  localparam logic [STEP_W-1:0] STEP_G4          = 4'd13;
  localparam logic [STEP_W-1:0] STEP_G5          = 4'd14;

  // permutation read address
  localparam logic [2:0] RD_NONE   = 3'd0;
  localparam logic [2:0] RD_I_NEXT = 3'd1;
  localparam logic [2:0] RD_I      = 3'd2;
  localparam logic [2:0] RD_J_NEW  = 3'd3;
  localparam logic [2:0] RD_AB     = 3'd4;

  // permutation write
  localparam logic [1:0] WR_NONE  = 2'd0;
  localparam logic [1:0] WR_I_IDX = 2'd1;
  localparam logic [1:0] WR_I_RD  = 2'd2;
  localparam logic [1:0] WR_J_A   = 2'd3;

  localparam logic [1:0] I_HOLD  = 2'd0;
  localparam logic [1:0] I_INC   = 2'd1;
  localparam logic [1:0] I_CLEAR = 2'd2;

  localparam logic [1:0] J_HOLD  = 2'd0;
  localparam logic [1:0] J_CLEAR = 2'd1;
  localparam logic [1:0] J_LOAD  = 2'd2;

  localparam logic [1:0] K_HOLD  = 2'd0;
  localparam logic [1:0] K_CLEAR = 2'd1;
  localparam logic [1:0] K_ADV   = 2'd2;

  localparam logic [1:0] EM_NONE = 2'd0;
  localparam logic [1:0] EM_DONE = 2'd1;
  localparam logic [1:0] EM_KEY  = 2'd2;

  localparam logic [2:0] JC_NEXT     = 3'd0;
  localparam logic [2:0] JC_ALWAYS   = 3'd1;
  localparam logic [2:0] JC_LOOP     = 3'd2;
  localparam logic [2:0] JC_SCHED    = 3'd3;
  localparam logic [2:0] JC_DISPATCH = 3'd4;

  typedef struct packed {
    logic [2:0]        rd_sel;
    logic [1:0]        wr_sel;
    logic [1:0]        i_op;
    logic [1:0]        j_op;
    logic [1:0]        k_op;
    logic              use_key;
    logic              a_ld;
    logic              b_ld;
    logic [1:0]        emit;
    logic [2:0]        jc;
    logic [STEP_W-1:0] target;
  } ctl_t;

  function automatic ctl_t ucode_rom(input logic [STEP_W-1:0] step);
    ctl_t w;
    w = '{rd_sel: RD_NONE, wr_sel: WR_NONE, i_op: I_HOLD, j_op: J_HOLD,
          k_op: K_HOLD, use_key: 1'b0, a_ld: 1'b0, b_ld: 1'b0,
          emit: EM_NONE, jc: JC_NEXT, target: STEP_IDLE};
    unique case (step)
      STEP_IDLE: begin
        w.jc = JC_DISPATCH;
      end
      STEP_SCHED_START: begin
        w.i_op = I_CLEAR;
      end
      STEP_FILL: begin
        w.wr_sel = WR_I_IDX;
        w.i_op   = I_INC;
        w.jc     = JC_LOOP;
        w.target = STEP_FILL;
      end
      STEP_KS_INIT: begin
        w.j_op   = J_CLEAR;
        w.k_op   = K_CLEAR;
        w.jc     = JC_SCHED;
        w.target = STEP_IDLE;
      end
      STEP_KS_A: begin
        w.rd_sel = RD_I;
      end
      STEP_KS_B: begin
        w.rd_sel  = RD_J_NEW;
        w.j_op    = J_LOAD;
        w.use_key = 1'b1;
        w.a_ld    = 1'b1;
      end
      STEP_KS_C: begin
        w.wr_sel = WR_I_RD;
      end
      STEP_KS_D: begin
        w.wr_sel = WR_J_A;
        w.i_op   = I_INC;
        w.k_op   = K_ADV;
        w.jc     = JC_LOOP;
        w.target = STEP_KS_A;
      end
      STEP_KS_END: begin
        w.j_op   = J_CLEAR;
        w.emit   = EM_DONE;
        w.jc     = JC_ALWAYS;
        w.target = STEP_IDLE;
      end
      STEP_G0: begin
        w.rd_sel = RD_I_NEXT;
        w.i_op   = I_INC;
      end
      STEP_G1: begin
        w.rd_sel = RD_J_NEW;
        w.j_op   = J_LOAD;
        w.a_ld   = 1'b1;
      end
      STEP_G2: begin
        w.wr_sel = WR_I_RD;
        w.b_ld   = 1'b1;
      end
      STEP_G3: begin
        w.wr_sel = WR_J_A;
      end
      STEP_G4: begin
        w.rd_sel = RD_AB;
      end
      STEP_G5: begin
        w.emit   = EM_KEY;
        w.jc     = JC_ALWAYS;
        w.target = STEP_IDLE;
      end
      default: begin
        w.jc     = JC_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[hdl/rc4_keystream_generator_unit.sv]
// Key load: no result. Keystream byte: six sequencer steps on the single-port
// permutation memory after the item is taken; no new item is taken until the
// result is emitted. Key schedule: identity fill of all 256 entries, then 4 steps
// per swap on the permutation memory, up to the done result.
// Reset is synchronous; afterwards an identity fill of the permutation runs
// with cmd_stall high. key_length resets to 16.
module rc4_keystream_generator_unit
  import rc4_pkg::*;
#(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [KEY_LEN_W-1:0] cfg_data,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  cmd_t                 cmd,
  output logic                 res_valid,
  input  logic                 res_stall,
  output res_t                 res
);

  logic [STEP_W-1:0]    pc;
  logic [STEP_W-1:0]    pc_next;
  logic                 sched;
  logic [KEY_LEN_W-1:0] key_length;
  ctl_t                 ctl;
  logic                 accept;
  logic                 out_free;
  logic                 emit_go;
  logic                 i_last;
  logic [7:0]           rdata;

  assign ctl       = ucode_rom(pc);
  assign cmd_stall = (pc != STEP_IDLE);
  assign accept    = cmd_valid && !cmd_stall;
  assign out_free  = !res_valid || !res_stall;
  assign emit_go   = (ctl.emit != EM_NONE) && out_free;

  always_comb begin
    pc_next = pc + STEP_W'(1);
    unique case (ctl.jc)
      JC_ALWAYS: pc_next = ctl.target;
      JC_LOOP:   pc_next = i_last ? pc + STEP_W'(1) : ctl.target;
      JC_SCHED:  pc_next = sched ? pc + STEP_W'(1) : ctl.target;
      JC_DISPATCH: begin
        pc_next = STEP_IDLE;
        if (accept) begin
          case (cmd.opcode)
            OP_SCHED: pc_next = STEP_SCHED_START;
            OP_GEN:   pc_next = STEP_G0;
            default:  pc_next = STEP_IDLE;
          endcase
        end
      end
      default: pc_next = pc + STEP_W'(1);
    endcase
    if ((ctl.emit != EM_NONE) && !out_free) begin
      pc_next = pc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc         <= STEP_FILL;
      sched      <= 1'b0;
      key_length <= KEY_LEN_RESET;
    end else begin
      pc <= pc_next;
      if (accept) begin
        sched <= (cmd.opcode == OP_SCHED);
      end
      if (cfg_we) begin
        key_length <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit_go) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_go) begin
      res.schedule_done  <= (ctl.emit == EM_DONE);
      res.keystream_byte <= (ctl.emit == EM_KEY) ? rdata : 8'd0;
    end
  end

  rc4_dp #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .key_we     (accept && (cmd.opcode == OP_LOAD)),
    .key_idx    (cmd.key_index),
    .key_val    (cmd.key_byte),
    .key_length (key_length),
    .i_last     (i_last),
    .rdata      (rdata)
  );

  a_res_source: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(pc) == STEP_KS_END || $past(pc) == STEP_G5))
    else $error("result raised outside an emit step");

  a_done_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.schedule_done |-> res.keystream_byte == 8'd0)
    else $error("schedule done item carries nonzero byte");

  a_sched_entry: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.opcode == OP_SCHED |=> pc == STEP_SCHED_START && sched)
    else $error("schedule item did not start the schedule program");

  a_emit_hold: assert property (@(posedge clk) disable iff (rst)
    ctl.emit != EM_NONE && res_valid && res_stall |=> $stable(pc))
    else $error("sequencer left an emit step while the output was full");

endmodule

[hdl/rc4_dp.sv]
module rc4_dp
  import rc4_pkg::*;
#(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ctl_t                 ctl,
  input  logic                 key_we,
  input  logic [7:0]           key_idx,
  input  logic [7:0]           key_val,
  input  logic [KEY_LEN_W-1:0] key_length,
  output logic                 i_last,
  output logic [7:0]           rdata
);

  localparam int KA_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam logic [KEY_LEN_W-1:0] MAX_LEN = KEY_LEN_W'(MAX_KEY_BYTES);

  logic [7:0] perm [256];
  logic [7:0] key_mem [MAX_KEY_BYTES];

  logic [7:0]           gi;
  logic [7:0]           gj;
  logic [KA_W-1:0]      kpos;
  logic [7:0]           a;
  logic [7:0]           b;
  logic [7:0]           kdata;
  logic [7:0]           j_new;
  logic [7:0]           rd_addr;
  logic [KEY_LEN_W-1:0] len_sat;
  logic [KEY_LEN_W-1:0] len_lim;
  logic                 key_ok;

  assign i_last = (gi == 8'hFF);
  assign j_new  = gj + rdata + (ctl.use_key ? kdata : 8'd0);
  assign key_ok = ({1'b0, key_idx} < MAX_LEN);

  always_comb begin
    if (key_length == '0) begin
      len_sat = KEY_LEN_W'(1);
    end else if (key_length > MAX_LEN) begin
      len_sat = MAX_LEN;
    end else begin
      len_sat = key_length;
    end
    len_lim = len_sat - KEY_LEN_W'(1);
  end

  always_comb begin
    case (ctl.rd_sel)
      RD_I_NEXT: rd_addr = gi + 8'd1;
      RD_I:      rd_addr = gi;
      RD_J_NEW:  rd_addr = j_new;
      RD_AB:     rd_addr = a + b;
      default:   rd_addr = gi;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_sel != RD_NONE) begin
      rdata <= perm[rd_addr];
    end
    case (ctl.wr_sel)
      WR_I_IDX: perm[gi] <= gi;
      WR_I_RD:  perm[gi] <= rdata;
      WR_J_A:   perm[gj] <= a;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    kdata <= key_mem[kpos];
    if (key_we && key_ok) begin
      key_mem[key_idx[KA_W-1:0]] <= key_val;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.a_ld) begin
      a <= rdata;
    end
    if (ctl.b_ld) begin
      b <= rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gi   <= '0;
      gj   <= '0;
      kpos <= '0;
    end else begin
      case (ctl.i_op)
        I_INC:   gi <= gi + 8'd1;
        I_CLEAR: gi <= '0;
        default: ;
      endcase
      case (ctl.j_op)
        J_CLEAR: gj <= '0;
        J_LOAD:  gj <= j_new;
        default: ;
      endcase
      case (ctl.k_op)
        K_CLEAR: kpos <= '0;
        K_ADV: begin
          if (KEY_LEN_W'(kpos) == len_lim) begin
            kpos <= '0;
          end else begin
            kpos <= kpos + KA_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[tb/sv/rc4_keystream_generator_unit_tb.sv]
`timescale 1ns / 1ps

module rc4_keystream_generator_unit_tb;
  import rc4_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int PERM_SIZE = 256;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [KEY_LEN_W-1:0] cfg_data;
  logic                 cmd_valid;
  logic                 cmd_stall;
  cmd_t                 cmd;
  logic                 res_valid;
  logic                 res_stall;
  res_t                 res;

  rc4_keystream_generator_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  // predicted cipher state
  logic [7:0]           perm_state [PERM_SIZE];
  logic [7:0]           key_mem [MAX_KEY_BYTES_DEF];
  bit                   key_written [MAX_KEY_BYTES_DEF];
  logic [7:0]           gen_i;
  logic [7:0]           gen_j;
  logic [KEY_LEN_W-1:0] key_len;

  res_t ks_expected [$];
  int   mismatch_count = 0;
  bit   no_idle = 0;
  int   res_hold_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic cmd_t make_cmd(input logic [1:0] op, input logic [7:0] idx,
                                    input logic [7:0] kb);
    cmd_t c;
    c.opcode    = op;
    c.key_index = idx;
    c.key_byte  = kb;
    return c;
  endfunction

  function automatic int eff_key_len();
    if (key_len == 0) return 1;
    if (key_len > MAX_KEY_BYTES_DEF) return MAX_KEY_BYTES_DEF;
    return int'(key_len);
  endfunction

  function automatic void model_cmd(input cmd_t c);
    logic [7:0] t;
    logic [7:0] j;
    int len;
    res_t r;
    case (c.opcode)
      OP_LOAD: begin
        key_mem[c.key_index]     = c.key_byte;
        key_written[c.key_index] = 1'b1;
      end
      OP_SCHED: begin
        len = eff_key_len();
        for (int n = 0; n < PERM_SIZE; n++) perm_state[n] = 8'(n);
        j = 8'd0;
        for (int n = 0; n < PERM_SIZE; n++) begin
          j = j + perm_state[n] + key_mem[n % len];
          t = perm_state[n];
          perm_state[n] = perm_state[j];
          perm_state[j] = t;
        end
        gen_i = 8'd0;
        gen_j = 8'd0;
        r.keystream_byte = 8'd0;
        r.schedule_done  = 1'b1;
        ks_expected.push_back(r);
      end
      OP_GEN: begin
        gen_i = gen_i + 8'd1;
        gen_j = gen_j + perm_state[gen_i];
        t = perm_state[gen_i];
        perm_state[gen_i] = perm_state[gen_j];
        perm_state[gen_j] = t;
        r.keystream_byte = perm_state[8'(perm_state[gen_i] + perm_state[gen_j])];
        r.schedule_done  = 1'b0;
        ks_expected.push_back(r);
      end
      default: ;
    endcase
  endfunction

  // valid is held until the item is taken
  task automatic send_cmd(input cmd_t c);
    while (!no_idle && $urandom_range(99) < 15) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    do @(posedge clk); while (cmd_stall);
    model_cmd(c);
  endtask

  task automatic wait_results_drained();
    cmd_valid <= 1'b0;
    while (ks_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_key_length(input logic [KEY_LEN_W-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    key_len = v;
  endtask

  // schedule must never read a key byte that was never loaded
  task automatic load_missing_key_bytes();
    for (int n = 0; n < eff_key_len(); n++)
      if (!key_written[n]) send_cmd(make_cmd(OP_LOAD, 8'(n), 8'($urandom_range(255))));
  endtask

  task automatic send_schedule();
    load_missing_key_bytes();
    send_cmd(make_cmd(OP_SCHED, 8'($urandom_range(255)), 8'($urandom_range(255))));
  endtask

  task automatic send_gen(input int count);
    for (int n = 0; n < count; n++)
      send_cmd(make_cmd(OP_GEN, 8'($urandom_range(255)), 8'($urandom_range(255))));
  endtask

  task automatic test_identity_stream_after_reset();
    send_gen(3);
    send_cmd(make_cmd(OP_UNUSED, 8'hFF, 8'hFF));
    send_gen(2);
  endtask

  task automatic test_reset_key_length();
    send_cmd(make_cmd(OP_LOAD, 8'd0, 8'hFF));
    send_cmd(make_cmd(OP_LOAD, 8'd1, 8'h00));
    send_cmd(make_cmd(OP_LOAD, 8'd255, 8'h5A));
    send_cmd(make_cmd(OP_UNUSED, 8'd2, 8'hAA));
    send_schedule();
    send_gen(4);
  endtask

  task automatic test_key_length_extremes();
    logic [KEY_LEN_W-1:0] lens [5];
    lens = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd300};
    foreach (lens[k]) begin
      wait_results_drained();
      write_key_length(lens[k]);
      send_schedule();
      send_gen(3);
    end
  endtask

  task automatic test_back_pressure();
    wait_results_drained();
    res_hold_cycles = 300;
    send_gen(40);
    wait_results_drained();
  endtask

  task automatic test_sender_pause();
    send_gen(10);
    wait_results_drained();
    send_gen(10);
    send_schedule();
    wait_results_drained();
    send_gen(5);
  endtask

  task automatic test_random_traffic();
    int r;
    logic [KEY_LEN_W-1:0] v;
    for (int phase = 0; phase < 5; phase++) begin
      wait_results_drained();
      case ($urandom_range(9))
        0: v = 9'd0;
        1: v = 9'd511;
        2: v = 9'd256;
        3: v = 9'($urandom_range(511));
        default: v = 9'($urandom_range(16, 1));
      endcase
      write_key_length(v);
      no_idle = (phase == 2);
      send_schedule();
      for (int n = 0; n < 60; n++) begin
        r = $urandom_range(99);
        if (r < 62) send_gen(1);
        else if (r < 84)
          send_cmd(make_cmd(OP_LOAD, 8'($urandom_range(255)), 8'($urandom_range(255))));
        else if (r < 88) send_schedule();
        else
          send_cmd(make_cmd(OP_UNUSED, 8'($urandom_range(255)), 8'($urandom_range(255))));
      end
      no_idle = 0;
    end
  endtask

  // receiver stall
  initial begin
    res_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_hold_cycles > 0) begin
        res_stall <= 1'b1;
        res_hold_cycles--;
      end else begin
        res_stall <= !no_idle && ($urandom_range(99) < 15);
      end
    end
  end

  // result check
  initial begin
    res_t want;
    forever begin
      @(posedge clk);
      if (!rst && res_valid && !res_stall) begin
        if (ks_expected.size() == 0) begin
          $error("unexpected item: keystream_byte %0h schedule_done %0b",
                 res.keystream_byte, res.schedule_done);
          mismatch_count++;
        end else begin
          want = ks_expected.pop_front();
          if (res.keystream_byte !== want.keystream_byte) begin
            $error("keystream_byte expected %0h actual %0h",
                   want.keystream_byte, res.keystream_byte);
            mismatch_count++;
          end
          if (res.schedule_done !== want.schedule_done) begin
            $error("schedule_done expected %0b actual %0b",
                   want.schedule_done, res.schedule_done);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_data  <= '0;
    cmd_valid <= 1'b0;
    cmd       <= '0;
    for (int n = 0; n < PERM_SIZE; n++) perm_state[n] = 8'(n);
    gen_i   = 8'd0;
    gen_j   = 8'd0;
    key_len = KEY_LEN_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_identity_stream_after_reset();
    test_reset_key_length();
    test_key_length_extremes();
    test_back_pressure();
    test_sender_pause();
    test_random_traffic();

    wait_results_drained();
    if (mismatch_count == 0 && ks_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
